### src/csvti_pkg.sv
`timescale 1ns / 1ps

package csvti_pkg;

    // Column and field type codes.
    localparam logic [1:0] TYPE_INT   = 2'd0;
    localparam logic [1:0] TYPE_FLOAT = 2'd1;
    localparam logic [1:0] TYPE_STR   = 2'd2;

    // Input item kinds.
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_NEWCOL = 2'd2;

    // Characters of the number syntax.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EXP_LO = 8'h65;
    localparam logic [7:0] CH_EXP_UP = 8'h45;

    typedef struct packed {
        logic [1:0] col_kind;
        logic [1:0] field_kind;
        logic       seen_dot;
        logic       seen_exp;
        logic       seen_digit;
        logic       digit_after_exp;
        logic       prev_was_exp;
        logic       at_field_start;
        logic       field_rejected;
    } t_scan_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } t_char_item;

    localparam t_scan_state STATE_RESET = '{
        col_kind:        TYPE_INT,
        field_kind:      TYPE_INT,
        seen_dot:        1'b0,
        seen_exp:        1'b0,
        seen_digit:      1'b0,
        digit_after_exp: 1'b0,
        prev_was_exp:    1'b0,
        at_field_start:  1'b1,
        field_rejected:  1'b0
    };

    // Clears the per-field flags and keeps the column type.
    function automatic t_scan_state clear_field(input t_scan_state s);
        t_scan_state r;
        r = STATE_RESET;
        r.col_kind = s.col_kind;
        return r;
    endfunction

endpackage

### src/csvti_in_stage.sv
`timescale 1ns / 1ps

module csvti_in_stage
    import csvti_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_char_item i_item,
    input  logic       i_advance,
    output logic       o_item_valid,
    output t_char_item o_item
);

    logic       r_valid;
    logic       n_valid;
    t_char_item r_item;
    logic       w_load;

    // The register holds while its item cannot move on to the scan stage.
    assign o_stall = r_valid && !i_advance;
    assign w_load  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

### src/csvti_step.sv
`timescale 1ns / 1ps

module csvti_step
    import csvti_pkg::*;
(
    input  t_scan_state i_state,
    input  t_char_item  i_item,
    output t_scan_state o_state,
    output logic        o_emit,
    output logic [1:0]  o_type
);

    t_scan_state s;
    logic        w_first;
    logic        w_after_exp;
    logic        w_is_float;
    logic        w_reject;
    logic        w_is_digit;

    assign w_is_digit = (i_item.ch >= CH_ZERO) && (i_item.ch <= CH_NINE);

    always_comb begin
        s           = i_state;
        o_emit      = 1'b0;
        w_first     = 1'b0;
        w_after_exp = 1'b0;
        w_is_float  = 1'b0;
        w_reject    = 1'b0;
        unique case (i_item.kind)
            KIND_NEWCOL: begin
                s          = STATE_RESET;
            end
            KIND_EMPTY: begin
                s          = STATE_RESET;
                s.col_kind = TYPE_STR;
                o_emit     = 1'b1;
            end
            KIND_CHAR: begin
                if (s.at_field_start) begin
                    s            = clear_field(s);
                    s.field_kind = s.col_kind;
                end
                if (s.col_kind != TYPE_STR && !s.field_rejected) begin
                    w_first        = s.at_field_start;
                    w_after_exp    = s.prev_was_exp;
                    w_is_float     = (s.field_kind == TYPE_FLOAT);
                    s.prev_was_exp = 1'b0;
                    if (w_is_digit) begin
                        s.seen_digit = 1'b1;
                        if (s.seen_exp) begin
                            s.digit_after_exp = 1'b1;
                        end
                    end else if (i_item.ch == CH_MINUS) begin
                        w_reject = !(w_first || (w_is_float && w_after_exp));
                    end else if (i_item.ch == CH_PLUS) begin
                        w_reject = !(w_is_float && (w_first || w_after_exp));
                    end else if (i_item.ch == CH_DOT) begin
                        if (s.seen_dot || s.seen_exp) begin
                            w_reject = 1'b1;
                        end else begin
                            s.seen_dot   = 1'b1;
                            s.field_kind = TYPE_FLOAT;
                        end
                    end else if (i_item.ch == CH_EXP_LO || i_item.ch == CH_EXP_UP) begin
                        if (s.seen_exp || !s.seen_digit) begin
                            w_reject = 1'b1;
                        end else begin
                            s.seen_exp     = 1'b1;
                            s.field_kind   = TYPE_FLOAT;
                            s.prev_was_exp = 1'b1;
                        end
                    end else begin
                        w_reject = 1'b1;
                    end
                    if (w_reject) begin
                        s.field_rejected = 1'b1;
                        s.col_kind       = TYPE_STR;
                    end
                end
                s.at_field_start = 1'b0;
                if (i_item.last) begin
                    // A field without digits, or with an empty exponent, is text.
                    if (s.col_kind != TYPE_STR && !s.field_rejected) begin
                        if (!s.seen_digit || (s.seen_exp && !s.digit_after_exp)) begin
                            s.col_kind = TYPE_STR;
                        end else begin
                            s.col_kind = s.field_kind;
                        end
                    end
                    s      = clear_field(s);
                    o_emit = 1'b1;
                end
            end
            default: begin
                s = i_state;
            end
        endcase
    end

    assign o_state = s;
    assign o_type  = s.col_kind;

endmodule

### src/csv_column_type_inference.sv
`timescale 1ns / 1ps
// A result is on o_column_type once the last character of its field has passed the input
// register, then the scan logic into the result register.
// Throughput: one character per cycle; the result register frees itself when
// its transfer completes, so the stream only stops while a result is stalled.
// Reset (synchronous, active low) sets the column type to integer at field start.
module csv_column_type_inference
    import csvti_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_column_type
);

    t_char_item  w_in_item;
    t_char_item  w_item;
    logic        w_item_valid;
    logic        w_advance;
    t_scan_state r_state;
    t_scan_state w_next_state;
    logic        w_emit;
    logic [1:0]  w_type;
    logic        r_out_valid;
    logic [1:0]  r_out_type;

    assign w_in_item = '{kind: i_kind, ch: i_ch, last: i_last};

    // The scan stage moves whenever the result register is free or being emptied.
    assign w_advance = !r_out_valid || !i_stall;

    csvti_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (w_in_item),
        .i_advance    (w_advance),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    csvti_step u_step (
        .i_state (r_state),
        .i_item  (w_item),
        .o_state (w_next_state),
        .o_emit  (w_emit),
        .o_type  (w_type)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_item_valid && w_emit;
            if (w_item_valid) begin
                r_state <= w_next_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_item_valid && w_emit) begin
            r_out_type <= w_type;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_column_type = r_out_type;

endmodule
